FILE: hdl/rv32i_execute_unit_core_defines.svh
// Assertion macros for the RV32I execute unit
`ifndef RV32I_EXECUTE_UNIT_CORE_DEFINES_SVH
`define RV32I_EXECUTE_UNIT_CORE_DEFINES_SVH

// same-cycle implication, checked on clk_i, off during reset
`define RVEX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i, off during reset
`define RVEX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rvex_pkg.sv
// Package: operation codes, result bundle and constants of the execute unit
`timescale 1ns / 1ps

package rvex_pkg;

  localparam int unsigned XLEN    = 32;
  localparam int unsigned KIND_W  = 6;
  localparam int unsigned SHAMT_W = 5;
  localparam int unsigned IMM_W   = 12;

  localparam logic [XLEN-1:0] HALT_ADDR_RESET = 32'h0003_0004;
  localparam logic [XLEN-1:0] PC_STEP         = 32'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD, KIND_SUB, KIND_XOR, KIND_OR, KIND_AND,
    KIND_SLL, KIND_SRL, KIND_SRA, KIND_SLT, KIND_SLTU,
    KIND_LB, KIND_LH, KIND_LW, KIND_LBU, KIND_LHU,
    KIND_ADDI, KIND_XORI, KIND_ORI, KIND_ANDI,
    KIND_SLLI, KIND_SRLI, KIND_SRAI, KIND_SLTI, KIND_SLTIU,
    KIND_SB, KIND_SH, KIND_SW,
    KIND_BEQ, KIND_BNE, KIND_BLT, KIND_BGE, KIND_BLTU, KIND_BGEU,
    KIND_LUI, KIND_AUIPC, KIND_JAL, KIND_JALR
  } kind_e;

  typedef struct packed {
    logic [XLEN-1:0] result_value;
    logic            writes_register;
    logic            branch_taken;
    logic            jump_valid;
    logic [XLEN-1:0] jump_target;
    logic [XLEN-1:0] memory_address;
    logic [XLEN-1:0] store_data;
    logic            halt_request;
  } result_t;

  function automatic logic [XLEN-1:0] sext12(input logic [XLEN-1:0] v);
    return {{(XLEN-IMM_W){v[IMM_W-1]}}, v[IMM_W-1:0]};
  endfunction

endpackage

FILE: hdl/rvex_alu.sv
// Combinational datapath of the execute unit: ALU, branch, jump and memory outputs
`timescale 1ns / 1ps

module rvex_alu (
  input  logic [rvex_pkg::KIND_W-1:0] kind_i,
  input  logic [rvex_pkg::XLEN-1:0]   a_i,
  input  logic [rvex_pkg::XLEN-1:0]   b_i,
  input  logic [rvex_pkg::XLEN-1:0]   imm_i,
  input  logic [rvex_pkg::XLEN-1:0]   pc_i,
  input  logic [rvex_pkg::XLEN-1:0]   halt_addr_i,
  output rvex_pkg::result_t           res_o
);

  logic [rvex_pkg::XLEN-1:0]    si;
  logic [rvex_pkg::XLEN-1:0]    ea;
  logic [rvex_pkg::XLEN-1:0]    link;
  logic [rvex_pkg::SHAMT_W-1:0] sh_r;
  logic [rvex_pkg::SHAMT_W-1:0] sh_i;
  logic                         lt_s;
  logic                         lt_u;
  logic                         lti_s;
  logic                         lti_u;

  assign si    = rvex_pkg::sext12(imm_i);
  assign ea    = a_i + si;
  assign link  = pc_i + rvex_pkg::PC_STEP;
  assign sh_r  = b_i[rvex_pkg::SHAMT_W-1:0];
  assign sh_i  = imm_i[rvex_pkg::SHAMT_W-1:0];
  assign lt_s  = $signed(a_i) < $signed(b_i);
  assign lt_u  = a_i < b_i;
  assign lti_s = $signed(a_i) < $signed(si);
  assign lti_u = a_i < si;

  always_comb begin
    res_o = '0;
    case (rvex_pkg::kind_e'(kind_i))
      rvex_pkg::KIND_ADD:   res_o.result_value = a_i + b_i;
      rvex_pkg::KIND_SUB:   res_o.result_value = a_i - b_i;
      rvex_pkg::KIND_XOR:   res_o.result_value = a_i ^ b_i;
      rvex_pkg::KIND_OR:    res_o.result_value = a_i | b_i;
      rvex_pkg::KIND_AND:   res_o.result_value = a_i & b_i;
      rvex_pkg::KIND_SLL:   res_o.result_value = a_i << sh_r;
      rvex_pkg::KIND_SRL:   res_o.result_value = a_i >> sh_r;
      rvex_pkg::KIND_SRA:   res_o.result_value = $unsigned($signed(a_i) >>> sh_r);
      rvex_pkg::KIND_SLT:   res_o.result_value = {{(rvex_pkg::XLEN-1){1'b0}}, lt_s};
      rvex_pkg::KIND_SLTU:  res_o.result_value = {{(rvex_pkg::XLEN-1){1'b0}}, lt_u};
      rvex_pkg::KIND_LB, rvex_pkg::KIND_LH, rvex_pkg::KIND_LW,
      rvex_pkg::KIND_LBU, rvex_pkg::KIND_LHU: res_o.memory_address = ea;
      rvex_pkg::KIND_ADDI:  res_o.result_value = ea;
      rvex_pkg::KIND_XORI:  res_o.result_value = a_i ^ si;
      rvex_pkg::KIND_ORI:   res_o.result_value = a_i | si;
      rvex_pkg::KIND_ANDI:  res_o.result_value = a_i & si;
      rvex_pkg::KIND_SLLI:  res_o.result_value = a_i << sh_i;
      rvex_pkg::KIND_SRLI:  res_o.result_value = a_i >> sh_i;
      rvex_pkg::KIND_SRAI:  res_o.result_value = $unsigned($signed(a_i) >>> sh_i);
      rvex_pkg::KIND_SLTI:  res_o.result_value = {{(rvex_pkg::XLEN-1){1'b0}}, lti_s};
      rvex_pkg::KIND_SLTIU: res_o.result_value = {{(rvex_pkg::XLEN-1){1'b0}}, lti_u};
      rvex_pkg::KIND_SB: begin
        res_o.memory_address = ea;
        res_o.store_data     = {{(rvex_pkg::XLEN-8){1'b0}}, b_i[7:0]};
        res_o.halt_request   = (ea == halt_addr_i);
      end
      rvex_pkg::KIND_SH: begin
        res_o.memory_address = ea;
        res_o.store_data     = {{(rvex_pkg::XLEN-16){1'b0}}, b_i[15:0]};
      end
      rvex_pkg::KIND_SW: begin
        res_o.memory_address = ea;
        res_o.store_data     = b_i;
      end
      rvex_pkg::KIND_BEQ:   res_o.branch_taken = (a_i == b_i);
      rvex_pkg::KIND_BNE:   res_o.branch_taken = (a_i != b_i);
      rvex_pkg::KIND_BLT:   res_o.branch_taken = lt_s;
      rvex_pkg::KIND_BGE:   res_o.branch_taken = !lt_s;
      rvex_pkg::KIND_BLTU:  res_o.branch_taken = lt_u;
      rvex_pkg::KIND_BGEU:  res_o.branch_taken = !lt_u;
      rvex_pkg::KIND_LUI:   res_o.result_value = imm_i;
      rvex_pkg::KIND_AUIPC: res_o.result_value = pc_i + imm_i;
      rvex_pkg::KIND_JAL:   res_o.result_value = link;
      rvex_pkg::KIND_JALR: begin
        res_o.result_value = link;
        res_o.jump_valid   = 1'b1;
        res_o.jump_target  = {ea[rvex_pkg::XLEN-1:1], 1'b0};
      end
      default: res_o = '0;
    endcase

    case (rvex_pkg::kind_e'(kind_i)) inside
      [rvex_pkg::KIND_ADD:rvex_pkg::KIND_SLTIU],
      [rvex_pkg::KIND_LUI:rvex_pkg::KIND_JALR]: res_o.writes_register = 1'b1;
      default: res_o.writes_register = 1'b0;
    endcase
  end

endmodule

FILE: hdl/rv32i_execute_unit_core.sv
// Top level of the RV32I execute unit: input register, datapath, result register
`timescale 1ns / 1ps
`include "rv32i_execute_unit_core_defines.svh"

// A transaction passes an input register for the operands, the single-pass
// datapath in rvex_alu (one 32-bit add and compare per path) that computes
// all outputs, and a result register that presents them. With out_ready_i
// held high the unit sustains one transaction per clock; an output stall
// holds the result register and, if the input register is full, drops
// in_ready_o in the same cycle. halt_address resets to 0x30004 and is written
// by cfg_we_i; the user must do so while the unit is idle (not enforced).
module rv32i_execute_unit_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rvex_pkg::XLEN-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rvex_pkg::KIND_W-1:0]         kind_i,
  input  logic [rvex_pkg::XLEN-1:0]           first_operand_i,
  input  logic [rvex_pkg::XLEN-1:0]           second_operand_i,
  input  logic [rvex_pkg::XLEN-1:0]           immediate_i,
  input  logic [rvex_pkg::XLEN-1:0]           instr_address_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rvex_pkg::XLEN-1:0]           result_value_o,
  output logic                                writes_register_o,
  output logic                                branch_taken_o,
  output logic                                jump_valid_o,
  output logic [rvex_pkg::XLEN-1:0]           jump_target_o,
  output logic [rvex_pkg::XLEN-1:0]           memory_address_o,
  output logic [rvex_pkg::XLEN-1:0]           store_data_o,
  output logic                                halt_request_o
);

  logic [rvex_pkg::XLEN-1:0]   halt_addr_q;
  logic                        s1_valid_q;
  logic [rvex_pkg::KIND_W-1:0] kind_q;
  logic [rvex_pkg::XLEN-1:0]   a_q;
  logic [rvex_pkg::XLEN-1:0]   b_q;
  logic [rvex_pkg::XLEN-1:0]   imm_q;
  logic [rvex_pkg::XLEN-1:0]   pc_q;
  logic                        out_valid_q;
  rvex_pkg::result_t           res_d;
  rvex_pkg::result_t           res_q;
  logic                        s2_load;
  logic                        s1_load;

  assign s2_load    = !out_valid_q || out_ready_i;
  assign s1_load    = !s1_valid_q || s2_load;
  assign in_ready_o = s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halt_addr_q <= rvex_pkg::HALT_ADDR_RESET;
    end else if (cfg_we_i) begin
      halt_addr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      kind_q <= kind_i;
      a_q    <= first_operand_i;
      b_q    <= second_operand_i;
      imm_q  <= immediate_i;
      pc_q   <= instr_address_i;
    end
    if (s2_load && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  rvex_alu u_alu (
    .kind_i      (kind_q),
    .a_i         (a_q),
    .b_i         (b_q),
    .imm_i       (imm_q),
    .pc_i        (pc_q),
    .halt_addr_i (halt_addr_q),
    .res_o       (res_d)
  );

  assign out_valid_o       = out_valid_q;
  assign result_value_o    = res_q.result_value;
  assign writes_register_o = res_q.writes_register;
  assign branch_taken_o    = res_q.branch_taken;
  assign jump_valid_o      = res_q.jump_valid;
  assign jump_target_o     = res_q.jump_target;
  assign memory_address_o  = res_q.memory_address;
  assign store_data_o      = res_q.store_data;
  assign halt_request_o    = res_q.halt_request;

  `RVEX_ASSERT_NEXT(a_stall_holds, s1_valid_q && !s1_load, s1_valid_q && $stable(kind_q), "held operands lost")
  `RVEX_ASSERT_IMP(a_halt_byte, out_valid_q && res_q.halt_request, !res_q.writes_register && res_q.store_data[rvex_pkg::XLEN-1:8] == '0, "halt on non-byte store")
  `RVEX_ASSERT_IMP(a_jump_link, out_valid_q && res_q.jump_valid, res_q.writes_register && !res_q.jump_target[0], "bad jalr result")
  `RVEX_ASSERT_IMP(a_branch_quiet, out_valid_q && res_q.branch_taken, !res_q.writes_register && res_q.result_value == '0, "branch writes register")

endmodule
